// ===== design/assert_macros.svh =====
// Assertion macros used by the top level of the modular inverse block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define BXG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BXG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`define BXG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define BXG_ASSERT(lbl, prop, msg)
`define BXG_ASSERT_IMPL(lbl, ante, cons, msg)
`define BXG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/bxgcd_pkg.sv =====
// Types shared by the controller and datapath of the modular inverse block.
`timescale 1ns / 1ps
`default_nettype none

package bxgcd_pkg;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_HALVE_U,
    OP_HALVE_V,
    OP_SUB,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    logic bad;
    logic u_zero;
    logic u_even;
    logic v_even;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/bxgcd_dp.sv =====
// Datapath of the modular inverse block: working values, coefficients and reduction.
`timescale 1ns / 1ps
`default_nettype none

module bxgcd_dp #(
  parameter int OPERAND_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [31:0]          cfg_wdata_i,
  input  wire logic [31:0]          operand_i,
  input  wire bxgcd_pkg::dp_op_e    op_i,
  output bxgcd_pkg::dp_status_t     status_o,
  output logic [31:0]               inverse_o,
  output logic                      invertible_o
);

  localparam int W  = OPERAND_BITS;
  localparam int CW = OPERAND_BITS + 3;

  logic [31:0]   mod_q;
  logic [W-1:0]  n_q, x_q, u_q, v_q, rem_q;
  logic [CW-1:0] a_q, b_q, c_q, d_q, dq_q;
  logic          bad_q, dneg_q;
  logic [31:0]   inv_q;
  logic          ok_q;

  logic [W-1:0]  n_in, x_in;
  logic          bad_in;
  logic [CW-1:0] xe, ne;
  logic          u_ge_v;
  logic          odd_u, odd_v;
  logic [CW-1:0] a_sum, b_sum, c_sum, d_sum;
  logic [CW-1:0] d_mag;
  logic [W:0]    r_shift, r_sub;
  logic [W-1:0]  rem_next, fin;
  logic          ok_next;

  assign n_in   = W'(mod_q);
  assign x_in   = W'(operand_i);
  assign bad_in = (n_in == '0) || (x_in == '0) || (!n_in[0] && !x_in[0]);

  assign xe = CW'(x_q);
  assign ne = CW'(n_q);
  assign u_ge_v = (u_q >= v_q);

  assign odd_u = a_q[0] | b_q[0];
  assign odd_v = c_q[0] | d_q[0];
  assign a_sum = odd_u ? a_q + xe : a_q;
  assign b_sum = odd_u ? b_q - ne : b_q;
  assign c_sum = odd_v ? c_q + xe : c_q;
  assign d_sum = odd_v ? d_q - ne : d_q;

  assign d_mag = d_q[CW-1] ? (CW'(0) - d_q) : d_q;

  assign r_shift  = {rem_q, dq_q[CW-1]};
  assign r_sub    = r_shift - {1'b0, n_q};
  assign rem_next = (r_shift >= {1'b0, n_q}) ? r_sub[W-1:0] : r_shift[W-1:0];

  assign fin     = (dneg_q && (rem_q != '0)) ? (n_q - rem_q) : rem_q;
  assign ok_next = !bad_q && (v_q == W'(1));

  assign status_o.bad    = bad_in;
  assign status_o.u_zero = (u_q == '0);
  assign status_o.u_even = !u_q[0];
  assign status_o.v_even = !v_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= 32'd1;
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      x_q    <= '0;
      u_q    <= '0;
      v_q    <= '0;
      rem_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      c_q    <= '0;
      d_q    <= '0;
      dq_q   <= '0;
      bad_q  <= 1'b0;
      dneg_q <= 1'b0;
      inv_q  <= 32'd0;
      ok_q   <= 1'b0;
    end else begin
      case (op_i)
        bxgcd_pkg::OP_LOAD: begin
          n_q   <= n_in;
          x_q   <= x_in;
          u_q   <= n_in;
          v_q   <= x_in;
          a_q   <= CW'(1);
          b_q   <= '0;
          c_q   <= '0;
          d_q   <= CW'(1);
          bad_q <= bad_in;
        end
        bxgcd_pkg::OP_HALVE_U: begin
          u_q <= u_q >> 1;
          a_q <= {a_sum[CW-1], a_sum[CW-1:1]};
          b_q <= {b_sum[CW-1], b_sum[CW-1:1]};
        end
        bxgcd_pkg::OP_HALVE_V: begin
          v_q <= v_q >> 1;
          c_q <= {c_sum[CW-1], c_sum[CW-1:1]};
          d_q <= {d_sum[CW-1], d_sum[CW-1:1]};
        end
        bxgcd_pkg::OP_SUB: begin
          if (u_ge_v) begin
            u_q <= u_q - v_q;
            a_q <= a_q - c_q;
            b_q <= b_q - d_q;
          end else begin
            v_q <= v_q - u_q;
            c_q <= c_q - a_q;
            d_q <= d_q - b_q;
          end
        end
        bxgcd_pkg::OP_DIV_LOAD: begin
          rem_q  <= '0;
          dq_q   <= d_mag;
          dneg_q <= d_q[CW-1];
        end
        bxgcd_pkg::OP_DIV_STEP: begin
          rem_q <= rem_next;
          dq_q  <= dq_q << 1;
        end
        bxgcd_pkg::OP_FINISH: begin
          ok_q  <= ok_next;
          inv_q <= ok_next ? 32'(fin) : 32'd0;
        end
        default: begin
        end
      endcase
    end
  end

  assign inverse_o    = inv_q;
  assign invertible_o = ok_q;

endmodule

`default_nettype wire

// ===== design/bxgcd_ctrl.sv =====
// Controller of the modular inverse block: sequences the GCD loop and the final reduction.
`timescale 1ns / 1ps
`default_nettype none

module bxgcd_ctrl #(
  parameter int OPERAND_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  bxgcd_pkg::dp_status_t     status_i,
  output bxgcd_pkg::dp_op_e         op_o,
  output logic                      busy_o,
  output logic                      done_o
);

  localparam int CW    = OPERAND_BITS + 3;
  localparam int CNT_W = $clog2(CW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_U,
    ST_RED_V,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e             state_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= status_i.bad ? ST_FINISH : ST_RED_U;
          end
        end
        ST_RED_U: begin
          if (status_i.u_zero) begin
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else if (!status_i.u_even) begin
            state_q <= ST_RED_V;
          end
        end
        ST_RED_V: begin
          if (!status_i.v_even) begin
            state_q <= ST_RED_U;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(CW - 1)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    op_o = bxgcd_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_o = bxgcd_pkg::OP_LOAD;
        end
      end
      ST_RED_U: begin
        if (status_i.u_zero) begin
          op_o = bxgcd_pkg::OP_DIV_LOAD;
        end else if (status_i.u_even) begin
          op_o = bxgcd_pkg::OP_HALVE_U;
        end
      end
      ST_RED_V: begin
        op_o = status_i.v_even ? bxgcd_pkg::OP_HALVE_V : bxgcd_pkg::OP_SUB;
      end
      ST_DIV: begin
        op_o = bxgcd_pkg::OP_DIV_STEP;
      end
      ST_FINISH: begin
        op_o = bxgcd_pkg::OP_FINISH;
      end
      default: begin
        op_o = bxgcd_pkg::OP_NONE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== design/binary_ext_gcd_mod_inverse_top.sv =====
// Top level of the modular inverse block by the binary extended GCD.
//
// Write the modulus through cfg_we_i and cfg_wdata_i while the block is idle; it
// resets to one. A transaction starts at a clock edge where start is high and busy
// is low, with the operand on operand_i. busy stays high until the result is out.
// The result appears on inverse_o and invertible_o and holds until the next
// transaction finishes; done_o marks it for exactly one cycle and the receiver
// cannot hold it off. When the operand has no inverse, invertible_o is low and
// inverse_o is zero. A zero operand, a zero modulus or two even inputs skip the
// GCD loop and go straight to the final step. Otherwise the loop halves u while
// it is even, then switches to the v reduction, halves v while it is even, then
// subtracts the smaller of u and v from the larger and returns to the u reduction,
// until u is zero. The final modular reduction of the coefficient is bit serial:
// a load and OPERAND_BITS + 3 steps, then a step to form the result and the strobe.
// One transaction is in flight at a time; the next may start in the cycle of the
// strobe. Reset returns the controller to idle and the modulus to one.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module binary_ext_gcd_mod_inverse_top #(
  parameter int OPERAND_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] operand_i,
  output logic             done_o,
  output logic [31:0]      inverse_o,
  output logic             invertible_o
);

  bxgcd_pkg::dp_op_e     op;
  bxgcd_pkg::dp_status_t status;

  bxgcd_ctrl #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .status_i(status),
    .op_o    (op),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  bxgcd_dp #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .operand_i   (operand_i),
    .op_i        (op),
    .status_o    (status),
    .inverse_o   (inverse_o),
    .invertible_o(invertible_o)
  );

  `BXG_ASSERT_NEXT(a_start_busy, start && !busy, busy, "Accepted transaction did not raise busy.")
  `BXG_ASSERT_IMPL(a_done_idle, done_o, !busy, "Result strobe while still busy.")
  `BXG_ASSERT_IMPL(a_zero_inv, done_o && !invertible_o, inverse_o == '0, "Stale inverse.")
  `BXG_ASSERT(a_done_pulse, !(done_o && $past(done_o)), "Result strobe held two cycles.")

endmodule

`default_nettype wire
